// ===== design/cmavg_pkg.sv =====
// Package for the centered moving average block: widths, FSM states and the
// divider request/response structs.
// No dependencies.
package cmavg_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int MAX_RADIUS = 31;
    localparam int RADIUS_W   = 5;
    localparam int CNT_W      = $clog2(2 * MAX_RADIUS + 2);
    localparam int ADDR_W     = 6;
    localparam int DEPTH      = 1 << ADDR_W;
    localparam int SUM_W      = 40;
    localparam int MAG_W      = SAMPLE_W + CNT_W - 1;
    localparam int CTR_W      = 32;
    localparam int REM_W      = $clog2(MAX_RADIUS + 2);
    localparam int STEP_W     = $clog2(MAG_W + 1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WAIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [MAG_W-1:0] mag;
        logic [CNT_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic [MAG_W-1:0] quot;
    } div_rsp_t;

endpackage

// ===== design/cmavg_if.sv =====
// Valid/ready channel interfaces: sample in, average out, radius config.
// Depends on cmavg_pkg.
interface cmavg_smp_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cmavg_pkg::SAMPLE_W-1:0] sample;
    logic                                 is_last;

    modport source (output valid, output sample, output is_last, input ready);
    modport sink   (input valid, input sample, input is_last, output ready);
endinterface

interface cmavg_avg_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [cmavg_pkg::SAMPLE_W-1:0] average;
    logic                                 last_out;

    modport source (output valid, output average, output last_out, input ready);
    modport sink   (input valid, input average, input last_out, output ready);
endinterface

interface cmavg_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [cmavg_pkg::RADIUS_W-1:0]   radius;

    modport source (output valid, output radius, input ready);
    modport sink   (input valid, input radius, output ready);
endinterface

// ===== design/cmavg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cmavg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/cmavg_div.sv =====
// Restoring divider, one quotient bit per cycle, for the rounded mean.
// Depends on cmavg_pkg.
module cmavg_div (
    input  logic                clk,
    input  logic                rst_n,
    input  cmavg_pkg::div_req_t req,
    output cmavg_pkg::div_rsp_t rsp
);
    import cmavg_pkg::*;

    logic              busy_reg, busy_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [CNT_W-1:0]  den_reg, den_next;
    logic [CNT_W:0]    trial;
    logic [CNT_W:0]    diff;
    logic              ge;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[MAG_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(MAG_W);
            quo_next  = req.mag;
            rem_next  = '0;
            den_next  = req.den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_next  = {quo_reg[MAG_W-2:0], ge};
            step_next = step_reg - 1'b1;
            busy_next = step_reg != STEP_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.quot = quo_reg;

endmodule

// ===== design/centered_moving_average.sv =====
// Centered moving average, truncated at record edges; top level.
// Depends on cmavg_pkg, cmavg_if, cmavg_ram, cmavg_div.
//
//  port  dir  payload            note
//  smp   in   sample, is_last    one word per sample
//  avg   out  average, last_out  one word per window mean
//  cfg   in   radius             write while idle
//
// A sample is taken while idle; each average it causes goes through these steps:
// store read and divider start, 37 quotient bits, output load. The next
// sample waits until its last average is loaded; a flush on the last
// sample gives up to radius+1 averages in turn.
// Reset clears counters, sum and FSM; the window store needs no clearing.
// A stalled avg holds the next average in the divider until taken.
module centered_moving_average (
    input  logic        clk,
    input  logic        rst_n,
    cmavg_smp_if.sink   smp,
    cmavg_avg_if.source avg,
    cmavg_cfg_if.sink   cfg
);
    import cmavg_pkg::*;

    state_t                     state_reg, state_next;
    logic [RADIUS_W-1:0]        radius_reg, radius_next;
    logic [RADIUS_W-1:0]        act_r_reg, act_r_next;
    logic [CTR_W-1:0]           seen_reg, seen_next;
    logic [CTR_W-1:0]           given_reg, given_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [ADDR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0]          newest_reg, newest_next;
    logic [REM_W-1:0]           rem_reg, rem_next;
    logic                       last_job_reg, last_job_next;
    logic                       full_left_reg, full_left_next;
    logic                       neg_reg, neg_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] avg_reg, avg_next;
    logic                       last_out_reg, last_out_next;

    logic                       smp_ready;
    logic                       div_start;
    logic                       ram_re;
    logic                       emit;
    logic                       smp_take;
    logic                       out_free;

    logic [CTR_W-1:0]           n_sat;
    logic [RADIUS_W-1:0]        r_use;
    logic [RADIUS_W-1:0]        r_cfg;
    logic [CTR_W-1:0]           pend_raw;
    logic [REM_W-1:0]           r_plus1;
    logic [REM_W-1:0]           pend;
    logic [REM_W-1:0]           outs;
    logic signed [SUM_W-1:0]    smp_ext;

    logic [RADIUS_W-1:0]        left;
    logic [RADIUS_W-1:0]        back;
    logic [CNT_W-1:0]           span;
    logic [CNT_W-1:0]           cnt;
    logic [SUM_W-1:0]           sum_abs;
    logic [ADDR_W-1:0]          rd_addr;

    logic [SAMPLE_W-1:0]        ram_rdata;
    logic signed [SUM_W-1:0]    old_ext;
    logic [SAMPLE_W-1:0]        quot32;

    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    cmavg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (smp_take),
        .waddr (wr_ptr_reg),
        .wdata (smp.sample),
        .re    (ram_re),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    cmavg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp_take && outs != '0)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (emit)
                begin
                    state_next = (rem_reg == REM_W'(1)) ? ST_IDLE : ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // FSM outputs
    always_comb
    begin
        smp_ready = 1'b0;
        div_start = 1'b0;
        ram_re    = 1'b0;
        emit      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                smp_ready = 1'b1;
            end
            ST_LOAD:
            begin
                div_start = 1'b1;
                ram_re    = 1'b1;
            end
            ST_WAIT:
            begin
                emit = !div_rsp.busy && out_free;
            end
            default:
            begin
                smp_ready = 1'b0;
            end
        endcase
    end

    assign smp_take = smp.valid && smp_ready;
    assign out_free = !out_valid_reg || avg.ready;

    // sample intake
    always_comb
    begin
        n_sat    = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
        r_cfg    = (radius_reg > RADIUS_W'(MAX_RADIUS)) ? RADIUS_W'(MAX_RADIUS) : radius_reg;
        r_use    = (seen_reg == '0) ? r_cfg : act_r_reg;
        pend_raw = (n_sat >= given_reg) ? n_sat - given_reg : '0;
        r_plus1  = REM_W'(r_use) + 1'b1;
        pend     = (pend_raw > CTR_W'(r_plus1)) ? r_plus1 : pend_raw[REM_W-1:0];
        if (smp.is_last)
        begin
            outs = pend;
        end
        else
        begin
            outs = (n_sat > CTR_W'(r_use)) ? REM_W'(1) : '0;
        end
        smp_ext = {{(SUM_W-SAMPLE_W){smp.sample[SAMPLE_W-1]}}, smp.sample};
    end

    // window setup for the next average
    always_comb
    begin
        left    = (given_reg < CTR_W'(act_r_reg)) ? given_reg[RADIUS_W-1:0] : act_r_reg;
        // mid-record the newest sample sits a full radius right of the center
        back    = last_job_reg ? RADIUS_W'(rem_reg - 1'b1) : act_r_reg;
        span    = CNT_W'(back) + CNT_W'(left);
        cnt     = span + 1'b1;
        sum_abs = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        rd_addr = newest_reg - ADDR_W'(span);
        div_req.start = div_start;
        div_req.mag   = MAG_W'(sum_abs) + MAG_W'(cnt >> 1);
        div_req.den   = cnt;
    end

    assign old_ext = {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
    assign quot32  = div_rsp.quot[SAMPLE_W-1:0];

    // datapath next values
    always_comb
    begin
        radius_next    = radius_reg;
        act_r_next     = act_r_reg;
        seen_next      = seen_reg;
        given_next     = given_reg;
        sum_next       = sum_reg;
        wr_ptr_next    = wr_ptr_reg;
        newest_next    = newest_reg;
        rem_next       = rem_reg;
        last_job_next  = last_job_reg;
        full_left_next = full_left_reg;
        neg_next       = neg_reg;
        out_valid_next = out_valid_reg;
        avg_next       = avg_reg;
        last_out_next  = last_out_reg;

        if (cfg.valid)
        begin
            radius_next = cfg.radius;
        end

        if (out_valid_reg && avg.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (smp_take)
        begin
            act_r_next    = r_use;
            wr_ptr_next   = wr_ptr_reg + 1'b1;
            newest_next   = wr_ptr_reg;
            rem_next      = outs;
            last_job_next = smp.is_last;
            if (smp.is_last && outs == '0)
            begin
                seen_next  = '0;
                given_next = '0;
                sum_next   = '0;
            end
            else
            begin
                seen_next = n_sat;
                sum_next  = sum_reg + smp_ext;
            end
        end

        if (div_start)
        begin
            full_left_next = left == act_r_reg;
            neg_next       = sum_reg[SUM_W-1];
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
            avg_next       = neg_reg ? -$signed(quot32) : $signed(quot32);
            last_out_next  = last_job_reg && rem_reg == REM_W'(1);
            rem_next       = rem_reg - 1'b1;
            if (last_job_reg && rem_reg == REM_W'(1))
            begin
                seen_next  = '0;
                given_next = '0;
                sum_next   = '0;
            end
            else
            begin
                given_next = (given_reg == '1) ? given_reg : given_reg + 1'b1;
                // drop the oldest sample once the left half is full
                sum_next   = full_left_reg ? sum_reg - old_ext : sum_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            radius_reg    <= RADIUS_RESET;
            act_r_reg     <= '0;
            seen_reg      <= '0;
            given_reg     <= '0;
            sum_reg       <= '0;
            wr_ptr_reg    <= '0;
            rem_reg       <= '0;
            last_job_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            radius_reg    <= radius_next;
            act_r_reg     <= act_r_next;
            seen_reg      <= seen_next;
            given_reg     <= given_next;
            sum_reg       <= sum_next;
            wr_ptr_reg    <= wr_ptr_next;
            rem_reg       <= rem_next;
            last_job_reg  <= last_job_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        newest_reg    <= newest_next;
        full_left_reg <= full_left_next;
        neg_reg       <= neg_next;
        avg_reg       <= avg_next;
        last_out_reg  <= last_out_next;
    end

    assign smp.ready    = smp_ready;
    assign cfg.ready    = 1'b1;
    assign avg.valid    = out_valid_reg;
    assign avg.average  = avg_reg;
    assign avg.last_out = last_out_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_work_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (rem_reg != '0))
        else $error("busy with no averages left");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg <= REM_W'(MAX_RADIUS + 1))
        else $error("more pending averages than radius+1");

    a_given_le_seen: assert property (@(posedge clk) disable iff (!rst_n)
        given_reg <= seen_reg)
        else $error("more averages than samples");

    a_record_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && last_job_reg && rem_reg == REM_W'(1))
        |=> (seen_reg == '0 && given_reg == '0 && sum_reg == '0 && state_reg == ST_IDLE))
        else $error("record state not cleared after last average");
`endif

endmodule
